// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks of the block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is low
`define DRS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// implication: when ante holds, cons holds in the same cycle
`define DRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	`DRS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ----- hw/rtl/drs_pkg.sv -----
// ---------------------------------------------------------------------------
// drs_pkg
// shared types and constants of the dns reply rrsig stripper
// ---------------------------------------------------------------------------
package drs_pkg;

	localparam int ADDR_BITS = 16;
	localparam int MAX_RES   = 4;

	localparam logic [ADDR_BITS-1:0] POS_MAX = {ADDR_BITS{1'b1}};

	localparam logic [15:0] DROP_TYPE_RST = 16'd46;

	// header layout
	localparam logic [3:0] HDR_LEN   = 4'd12;
	localparam logic [3:0] HDR_QD_HI = 4'd4;
	localparam logic [3:0] HDR_QD_LO = 4'd5;
	localparam logic [3:0] HDR_AN_HI = 4'd6;
	localparam logic [3:0] HDR_AN_LO = 4'd7;

	localparam logic [3:0] Q_FIX_LEN = 4'd4;
	localparam logic [3:0] A_FIX_LEN = 4'd10;

	// parser phases
	localparam logic [3:0] PH_HDR    = 4'd0;
	localparam logic [3:0] PH_Q_LEN  = 4'd1;
	localparam logic [3:0] PH_Q_LBL  = 4'd2;
	localparam logic [3:0] PH_Q_PTR  = 4'd3;
	localparam logic [3:0] PH_Q_FIX  = 4'd4;
	localparam logic [3:0] PH_A_LEN  = 4'd5;
	localparam logic [3:0] PH_A_LBL  = 4'd6;
	localparam logic [3:0] PH_A_PTR  = 4'd7;
	localparam logic [3:0] PH_A_FIX  = 4'd8;
	localparam logic [3:0] PH_A_DATA = 4'd9;
	localparam logic [3:0] PH_REST   = 4'd10;
	localparam logic [3:0] PH_ERR    = 4'd11;

	// result kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	// done status
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR = 3'd1;
	localparam logic [2:0] ST_NO_Q      = 3'd2;
	localparam logic [2:0] ST_MULTI_Q   = 3'd3;
	localparam logic [2:0] ST_BAD_Q     = 3'd4;
	localparam logic [2:0] ST_BAD_ANS   = 3'd5;

	// label length byte top bits
	localparam logic [1:0] LBL_PTR = 2'b11;
	localparam logic [1:0] LBL_X01 = 2'b01;
	localparam logic [1:0] LBL_X10 = 2'b10;

	typedef struct packed {
		logic        kind;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic [2:0]  status;
		logic [15:0] out_length;
		logic        final_item;
	} res_t;

	typedef struct packed {
		logic       load;
		logic [2:0] cnt;
	} load_t;

endpackage

// ----- hw/rtl/drs_reply_if.sv -----
// ---------------------------------------------------------------------------
// drs_reply_if
// request channel carrying reply bytes into the stripper
// ---------------------------------------------------------------------------
interface drs_reply_if;
	logic       valid;
	logic       ready;
	logic [7:0] reply_byte;
	logic       end_of_reply;

	modport source (output valid, output reply_byte, output end_of_reply, input ready);
	modport sink   (input valid, input reply_byte, input end_of_reply, output ready);
endinterface

// ----- hw/rtl/drs_result_if.sv -----
// ---------------------------------------------------------------------------
// drs_result_if
// request channel carrying buffer writes and done items out of the stripper
// ---------------------------------------------------------------------------
interface drs_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] write_addr;
	logic [7:0]  write_data;
	logic [2:0]  status;
	logic [15:0] out_length;
	logic        final_item;

	modport source (output valid, output kind, output write_addr, output write_data,
		output status, output out_length, output final_item, input ready);
	modport sink   (input valid, input kind, input write_addr, input write_data,
		input status, input out_length, input final_item, output ready);
endinterface

// ----- hw/rtl/dns_reply_rrsig_stripper.sv -----
// ---------------------------------------------------------------------------
// dns_reply_rrsig_stripper
// copies a dns reply into an output buffer, dropping answers of one type
// ---------------------------------------------------------------------------
// Takes one reply byte per cycle, unless the result bank is still busy, and
// turns it into addressed buffer writes. A byte goes through an input
// register, is parsed combinationally, and its results are loaded into a
// four-entry result bank that offers them. Each byte causes at most one write,
// so the input keeps a rate of one byte per cycle while the result side takes
// one request per cycle. The last byte of a good reply adds two header patch
// writes and a done item, up to four results in all; the bank hands them out
// one per cycle while the result side is ready, and the input is held until
// the last of them goes out. A failed reply ends with a single done item.
// drop_type may only be written while no reply byte is in flight.
module dns_reply_rrsig_stripper (
	input  logic          clk,
	input  logic          arst_n,
	drs_reply_if.sink     reply,
	drs_result_if.source  result,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);

	drs_pkg::res_t [drs_pkg::MAX_RES-1:0] res;
	drs_pkg::load_t                       ld;
	logic                                 buf_free;

	drs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.reply     (reply),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.buf_free  (buf_free),
		.res       (res),
		.ld        (ld)
	);

	drs_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.ld       (ld),
		.buf_free (buf_free),
		.result   (result)
	);

endmodule

// ----- hw/rtl/drs_core.sv -----
// ---------------------------------------------------------------------------
// drs_core
// input register, parser state and per-byte result generation
// ---------------------------------------------------------------------------
module drs_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	drs_reply_if.sink                             reply,
	input  logic                                  cfg_we,
	input  logic [15:0]                           cfg_wdata,
	input  logic                                  buf_free,
	output drs_pkg::res_t [drs_pkg::MAX_RES-1:0]  res,
	output drs_pkg::load_t                        ld
);

	localparam int AB = drs_pkg::ADDR_BITS;

	logic [7:0]    byte_s1;
	logic          eor_s1;
	logic          valid_s1;
	logic          advance;
	logic          accept;

	logic [15:0]   drop_q;
	logic [3:0]    ph_q, ph_d;
	logic [3:0]    hdr_q, hdr_d;
	logic [AB-1:0] pos_q, pos_d, pos_cur, pos_after;
	logic [AB-1:0] ros_q, ros_d;
	logic [15:0]   aleft_q, aleft_d, aleft_sa;
	logic [15:0]   kept_q, kept_d;
	logic [7:0]    lbl_q, lbl_d;
	logic [3:0]    fix_q, fix_d;
	logic [15:0]   rtype_q, rtype_d, rt_new;
	logic [15:0]   dleft_q, dleft_d, dl_new;
	logic          drop_q2, drop_d, drop_now;
	logic [2:0]    err_q, err_d;

	logic          emit_req, emitted, end_rec, start_ans;
	logic [2:0]    status;
	logic [2:0]    n;
	logic [1:0]    wi;
	drs_pkg::res_t [drs_pkg::MAX_RES-1:0] r;

	function automatic drs_pkg::res_t mk_write(logic [15:0] a, logic [7:0] d);
		drs_pkg::res_t x;
		x            = '0;
		x.kind       = drs_pkg::KIND_WRITE;
		x.write_addr = a;
		x.write_data = d;
		return x;
	endfunction

	function automatic drs_pkg::res_t mk_done(logic [2:0] st, logic [15:0] len);
		drs_pkg::res_t x;
		x            = '0;
		x.kind       = drs_pkg::KIND_DONE;
		x.status     = st;
		x.out_length = len;
		return x;
	endfunction

	assign accept      = reply.valid && reply.ready;
	assign advance     = valid_s1 && (n == 3'd0 || buf_free);
	assign reply.ready = !valid_s1 || advance;
	assign ld.load     = advance && (n != 3'd0);
	assign ld.cnt      = n;
	assign res         = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= reply.reply_byte;
			eor_s1  <= reply.end_of_reply;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= drs_pkg::DROP_TYPE_RST;
		end else if (cfg_we) begin
			drop_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= drs_pkg::PH_HDR;
			hdr_q   <= '0;
			pos_q   <= '0;
			ros_q   <= '0;
			aleft_q <= '0;
			kept_q  <= '0;
			lbl_q   <= '0;
			fix_q   <= '0;
			rtype_q <= '0;
			dleft_q <= '0;
			drop_q2 <= 1'b0;
			err_q   <= '0;
		end else if (advance) begin
			ph_q    <= ph_d;
			hdr_q   <= hdr_d;
			pos_q   <= pos_d;
			ros_q   <= ros_d;
			aleft_q <= aleft_d;
			kept_q  <= kept_d;
			lbl_q   <= lbl_d;
			fix_q   <= fix_d;
			rtype_q <= rtype_d;
			dleft_q <= dleft_d;
			drop_q2 <= drop_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		ph_d      = ph_q;
		hdr_d     = (hdr_q == drs_pkg::HDR_LEN) ? hdr_q : hdr_q + 4'd1;
		pos_cur   = pos_q;
		ros_d     = ros_q;
		aleft_d   = aleft_q;
		kept_d    = kept_q;
		lbl_d     = lbl_q;
		fix_d     = fix_q;
		rtype_d   = rtype_q;
		dleft_d   = dleft_q;
		drop_d    = drop_q2;
		err_d     = err_q;
		emit_req  = 1'b0;
		end_rec   = 1'b0;
		start_ans = 1'b0;
		aleft_sa  = aleft_q;
		drop_now  = drop_q2;
		rt_new    = {rtype_q[15:8], byte_s1};
		dl_new    = {dleft_q[15:8], byte_s1};

		unique case (ph_q)
			drs_pkg::PH_HDR: begin
				if (hdr_q == drs_pkg::HDR_QD_HI) begin
					rtype_d = {8'd0, byte_s1};
				end
				if (hdr_q == drs_pkg::HDR_QD_LO && rtype_q[7:0] == 8'd0 && byte_s1 == 8'd0) begin
					err_d = drs_pkg::ST_NO_Q;
					ph_d  = drs_pkg::PH_ERR;
				end else if (hdr_q == drs_pkg::HDR_QD_LO
						&& (rtype_q[7:0] != 8'd0 || byte_s1 > 8'd1)) begin
					err_d = drs_pkg::ST_MULTI_Q;
					ph_d  = drs_pkg::PH_ERR;
				end else begin
					if (hdr_q == drs_pkg::HDR_AN_HI) begin
						aleft_d = {byte_s1, 8'd0};
					end
					if (hdr_q == drs_pkg::HDR_AN_LO) begin
						aleft_d = {aleft_q[15:8], byte_s1};
					end
					emit_req = 1'b1;
					if (hdr_q == drs_pkg::HDR_LEN - 4'd1) begin
						ph_d = drs_pkg::PH_Q_LEN;
					end
				end
			end
			drs_pkg::PH_Q_LEN, drs_pkg::PH_A_LEN: begin
				if (byte_s1[7:6] == drs_pkg::LBL_X01 || byte_s1[7:6] == drs_pkg::LBL_X10) begin
					err_d = (ph_q == drs_pkg::PH_Q_LEN) ? drs_pkg::ST_BAD_Q : drs_pkg::ST_BAD_ANS;
					ph_d  = drs_pkg::PH_ERR;
				end else begin
					emit_req = 1'b1;
					if (byte_s1 == 8'd0) begin
						fix_d = '0;
						ph_d  = ph_q + 4'd3;
					end else if (byte_s1[7:6] == drs_pkg::LBL_PTR) begin
						ph_d = ph_q + 4'd2;
					end else begin
						lbl_d = byte_s1;
						ph_d  = ph_q + 4'd1;
					end
				end
			end
			drs_pkg::PH_Q_LBL, drs_pkg::PH_A_LBL: begin
				emit_req = 1'b1;
				lbl_d    = lbl_q - 8'd1;
				if (lbl_q == 8'd1) begin
					ph_d = ph_q - 4'd1;
				end
			end
			drs_pkg::PH_Q_PTR, drs_pkg::PH_A_PTR: begin
				emit_req = 1'b1;
				fix_d    = '0;
				ph_d     = ph_q + 4'd1;
			end
			drs_pkg::PH_Q_FIX: begin
				emit_req = 1'b1;
				fix_d    = fix_q + 4'd1;
				if (fix_q + 4'd1 == drs_pkg::Q_FIX_LEN) begin
					start_ans = 1'b1;
				end
			end
			drs_pkg::PH_A_FIX: begin
				if (fix_q == 4'd0) begin
					rtype_d = {byte_s1, 8'd0};
				end
				if (fix_q == 4'd1) begin
					rtype_d = rt_new;
					if (rt_new == drop_q) begin
						drop_d   = 1'b1;
						drop_now = 1'b1;
						pos_cur  = ros_q;
					end
				end
				// rdlength sits in the last two fixed bytes
				if (fix_q == 4'd8) begin
					dleft_d = {byte_s1, 8'd0};
				end
				if (fix_q == 4'd9) begin
					dleft_d = dl_new;
				end
				emit_req = !drop_now;
				fix_d    = fix_q + 4'd1;
				if (fix_q + 4'd1 == drs_pkg::A_FIX_LEN) begin
					if (dl_new == 16'd0) begin
						end_rec = 1'b1;
					end else begin
						ph_d = drs_pkg::PH_A_DATA;
					end
				end
			end
			drs_pkg::PH_A_DATA: begin
				emit_req = !drop_q2;
				dleft_d  = dleft_q - 16'd1;
				if (dleft_q == 16'd1) begin
					end_rec = 1'b1;
				end
			end
			drs_pkg::PH_REST: begin
				emit_req = 1'b1;
			end
			default: begin
			end
		endcase

		emitted   = emit_req && (pos_cur != drs_pkg::POS_MAX);
		pos_after = pos_cur + AB'(emitted);
		pos_d     = pos_after;

		if (end_rec) begin
			if (!drop_now) begin
				kept_d = kept_q + 16'd1;
			end
			drop_d    = 1'b0;
			aleft_d   = aleft_q - 16'd1;
			aleft_sa  = aleft_q - 16'd1;
			start_ans = 1'b1;
		end

		if (start_ans) begin
			if (aleft_sa == 16'd0) begin
				ph_d = drs_pkg::PH_REST;
			end else begin
				ros_d = pos_after;
				ph_d  = drs_pkg::PH_A_LEN;
			end
		end

		// results of this byte
		r    = '0;
		r[0] = mk_write(16'(pos_cur), byte_s1);
		n    = {2'd0, emitted};
		wi   = {1'b0, emitted};

		if (hdr_d < drs_pkg::HDR_LEN) begin
			status = drs_pkg::ST_SHORT_HDR;
		end else if (ph_d == drs_pkg::PH_ERR) begin
			status = err_d;
		end else if (ph_d == drs_pkg::PH_REST) begin
			status = drs_pkg::ST_OK;
		end else if (ph_d >= drs_pkg::PH_Q_LEN && ph_d <= drs_pkg::PH_Q_FIX) begin
			status = drs_pkg::ST_BAD_Q;
		end else begin
			status = drs_pkg::ST_BAD_ANS;
		end

		if (eor_s1) begin
			if (status == drs_pkg::ST_OK) begin
				// patch the answer count in the copied header
				r[wi]        = mk_write(16'(drs_pkg::HDR_AN_HI), kept_d[15:8]);
				r[wi + 2'd1] = mk_write(16'(drs_pkg::HDR_AN_LO), kept_d[7:0]);
				r[wi + 2'd2] = mk_done(drs_pkg::ST_OK, 16'(pos_after));
				n            = n + 3'd3;
			end else begin
				r[wi] = mk_done(status, 16'd0);
				n     = n + 3'd1;
			end
			ph_d    = drs_pkg::PH_HDR;
			hdr_d   = '0;
			pos_d   = '0;
			ros_d   = '0;
			aleft_d = '0;
			kept_d  = '0;
			lbl_d   = '0;
			fix_d   = '0;
			rtype_d = '0;
			dleft_d = '0;
			drop_d  = 1'b0;
			err_d   = '0;
		end

		for (int i = 0; i < drs_pkg::MAX_RES; i++) begin
			r[i].final_item = (3'(i) + 3'd1 == n);
		end
	end

endmodule

// ----- hw/rtl/drs_outbuf.sv -----
// ---------------------------------------------------------------------------
// drs_outbuf
// result register bank, drained one request per cycle while the result side is ready
// ---------------------------------------------------------------------------
module drs_outbuf (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  drs_pkg::res_t [drs_pkg::MAX_RES-1:0]  res,
	input  drs_pkg::load_t                        ld,
	output logic                                  buf_free,
	drs_result_if.source                          result
);

	drs_pkg::res_t [drs_pkg::MAX_RES-1:0] slot_s2;
	logic [1:0] rd_q;
	logic [2:0] left_q;
	logic       take;
	drs_pkg::res_t head;

	assign head     = slot_s2[rd_q];
	assign take     = result.valid && result.ready;
	assign buf_free = (left_q == 3'd0) || (left_q == 3'd1 && result.ready);

	assign result.valid      = (left_q != 3'd0);
	assign result.kind       = head.kind;
	assign result.write_addr = head.write_addr;
	assign result.write_data = head.write_data;
	assign result.status     = head.status;
	assign result.out_length = head.out_length;
	assign result.final_item = head.final_item;

	always_ff @(posedge clk) begin
		if (ld.load) begin
			slot_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			left_q <= '0;
		end else if (ld.load) begin
			rd_q   <= '0;
			left_q <= ld.cnt;
		end else if (take) begin
			rd_q   <= rd_q + 2'd1;
			left_q <= left_q - 3'd1;
		end
	end

endmodule

// ----- hw/rtl/drs_checker.sv -----
// ---------------------------------------------------------------------------
// drs_checker
// port-level checks on the result channel of the stripper
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module drs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        kind,
	input logic [2:0]  status,
	input logic [15:0] out_length,
	input logic        final_item
);

	// a stalled result stays offered
	`DRS_ASSERT(a_hold, clk, arst_n, res_valid && !res_ready |=> res_valid)

	// a done item always closes the results of its byte
	`DRS_ASSERT_IMP(a_done_last, clk, arst_n, res_valid && kind == drs_pkg::KIND_DONE, final_item)

	// failed replies report no length
	`DRS_ASSERT_IMP(a_fail_len, clk, arst_n,
		res_valid && kind == drs_pkg::KIND_DONE && status != drs_pkg::ST_OK, out_length == 16'd0)

	// writes carry neither status nor length
	`DRS_ASSERT_IMP(a_write_clean, clk, arst_n, res_valid && kind == drs_pkg::KIND_WRITE,
		status == drs_pkg::ST_OK && out_length == 16'd0)

endmodule

bind dns_reply_rrsig_stripper drs_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.kind       (result.kind),
	.status     (result.status),
	.out_length (result.out_length),
	.final_item (result.final_item)
);

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// checks the dns reply rrsig stripper: replies go in byte by byte, and every
// buffer write and done item that comes out is compared in order with a
// behavioral copy of the parser kept inside this bench
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import drs_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	drs_reply_if  reply();
	drs_result_if result();

	dns_reply_rrsig_stripper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.reply     (reply),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	bit   calm;
	int   bad_count;
	int   bytes_sent;
	int   cycle_count;
	res_t buffer_ops[$];
	res_t step_ops[$];
	logic [7:0] pkt[$];

	// parser copy
	logic [15:0] strip_type;
	logic [3:0]  ph;
	logic [15:0] rx_count, wr_pos, rec_base;
	logic [15:0] an_total, an_left, an_kept;
	logic [7:0]  lbl_cnt;
	logic [3:0]  fix_cnt;
	logic [15:0] rr_type, rd_left;
	logic        skip_rec;
	logic [2:0]  fail_code;

	task automatic clear_model();
		ph = PH_HDR;
		rx_count = '0; wr_pos = '0; rec_base = '0;
		an_total = '0; an_left = '0; an_kept = '0;
		lbl_cnt = '0; fix_cnt = '0; rr_type = '0; rd_left = '0;
		skip_rec = 1'b0; fail_code = ST_OK;
	endtask

	task automatic push_op(input logic kind, input logic [15:0] addr, input logic [7:0] data,
		input logic [2:0] st, input logic [15:0] len);
		res_t r;
		r.kind = kind;
		r.write_addr = addr;
		r.write_data = data;
		r.status = st;
		r.out_length = len;
		r.final_item = 1'b0;
		step_ops.push_back(r);
	endtask

	// a write at the last offset is dropped, the buffer is full
	task automatic emit_write(input logic [7:0] b);
		if (wr_pos != POS_MAX) begin
			push_op(KIND_WRITE, wr_pos, b, ST_OK, 16'd0);
			wr_pos = wr_pos + 16'd1;
		end
	endtask

	task automatic fail_with(input logic [2:0] code);
		fail_code = code;
		ph = PH_ERR;
	endtask

	task automatic begin_answers();
		if (an_left == 16'd0) begin
			ph = PH_REST;
		end else begin
			rec_base = wr_pos;
			ph = PH_A_LEN;
		end
	endtask

	task automatic close_record();
		if (!skip_rec)
			an_kept = an_kept + 16'd1;
		skip_rec = 1'b0;
		an_left = an_left - 16'd1;
		begin_answers();
	endtask

	task automatic name_byte(input logic [7:0] b, input logic [3:0] base, input logic [2:0] code);
		if (b[7:6] == LBL_X01 || b[7:6] == LBL_X10) begin
			fail_with(code);
		end else begin
			emit_write(b);
			if (b == 8'd0) begin
				fix_cnt = '0;
				ph = base + 4'd3;
			end else if (b[7:6] == LBL_PTR) begin
				ph = base + 4'd2;
			end else begin
				lbl_cnt = b;
				ph = base + 4'd1;
			end
		end
	endtask

	// works out every request caused by one accepted reply byte
	task automatic strip_step(input logic [7:0] b, input logic eor);
		logic [15:0] idx;
		logic [2:0]  st;
		step_ops.delete();
		idx = rx_count;
		if (rx_count != 16'hffff)
			rx_count = rx_count + 16'd1;
		case (ph)
			PH_HDR: begin
				if (idx == 16'(HDR_QD_HI))
					rr_type = {8'h00, b};
				if (idx == 16'(HDR_QD_LO) && {rr_type[7:0], b} == 16'd0) begin
					fail_with(ST_NO_Q);
				end else if (idx == 16'(HDR_QD_LO) && {rr_type[7:0], b} > 16'd1) begin
					fail_with(ST_MULTI_Q);
				end else begin
					if (idx == 16'(HDR_AN_HI))
						an_total = {b, 8'h00};
					if (idx == 16'(HDR_AN_LO)) begin
						an_total[7:0] = b;
						an_left = an_total;
					end
					emit_write(b);
					if (idx == 16'(HDR_LEN - 4'd1))
						ph = PH_Q_LEN;
				end
			end
			PH_Q_LEN: name_byte(b, PH_Q_LEN, ST_BAD_Q);
			PH_A_LEN: name_byte(b, PH_A_LEN, ST_BAD_ANS);
			PH_Q_LBL, PH_A_LBL: begin
				emit_write(b);
				lbl_cnt = lbl_cnt - 8'd1;
				if (lbl_cnt == 8'd0)
					ph = ph - 4'd1;
			end
			PH_Q_PTR, PH_A_PTR: begin
				emit_write(b);
				fix_cnt = '0;
				ph = ph + 4'd1;
			end
			PH_Q_FIX: begin
				emit_write(b);
				fix_cnt = fix_cnt + 4'd1;
				if (fix_cnt == Q_FIX_LEN)
					begin_answers();
			end
			PH_A_FIX: begin
				if (fix_cnt == 4'd0)
					rr_type = {b, 8'h00};
				if (fix_cnt == 4'd1) begin
					rr_type[7:0] = b;
					// matching type: rewind over what was already written
					if (rr_type == strip_type) begin
						skip_rec = 1'b1;
						wr_pos = rec_base;
					end
				end
				if (fix_cnt == 4'd8)
					rd_left = {b, 8'h00};
				if (fix_cnt == 4'd9)
					rd_left[7:0] = b;
				if (!skip_rec)
					emit_write(b);
				fix_cnt = fix_cnt + 4'd1;
				if (fix_cnt == A_FIX_LEN) begin
					if (rd_left == 16'd0)
						close_record();
					else
						ph = PH_A_DATA;
				end
			end
			PH_A_DATA: begin
				if (!skip_rec)
					emit_write(b);
				rd_left = rd_left - 16'd1;
				if (rd_left == 16'd0)
					close_record();
			end
			PH_REST: emit_write(b);
			default: ;
		endcase
		if (eor) begin
			if (rx_count < 16'(HDR_LEN))
				st = ST_SHORT_HDR;
			else if (ph == PH_ERR)
				st = fail_code;
			else if (ph == PH_REST)
				st = ST_OK;
			else if (ph >= PH_Q_LEN && ph <= PH_Q_FIX)
				st = ST_BAD_Q;
			else
				st = ST_BAD_ANS;
			if (st == ST_OK) begin
				push_op(KIND_WRITE, 16'(HDR_AN_HI), an_kept[15:8], ST_OK, 16'd0);
				push_op(KIND_WRITE, 16'(HDR_AN_LO), an_kept[7:0], ST_OK, 16'd0);
				push_op(KIND_DONE, 16'd0, 8'd0, ST_OK, wr_pos);
			end else begin
				push_op(KIND_DONE, 16'd0, 8'd0, st, 16'd0);
			end
			clear_model();
		end
		if (step_ops.size() > 0)
			step_ops[step_ops.size() - 1].final_item = 1'b1;
		foreach (step_ops[i])
			buffer_ops.push_back(step_ops[i]);
	endtask

	// ---- reply building ----

	task automatic add_rand(input int n);
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	task automatic add_header(input logic [15:0] qd, input logic [15:0] an);
		add_rand(4);
		pkt = {pkt, qd[15:8], qd[7:0], an[15:8], an[7:0]};
		add_rand(4);
	endtask

	// root, pointer, or a few labels ended by root or pointer
	task automatic add_name();
		int form;
		logic [7:0] v;
		form = $urandom_range(0, 3);
		if (form == 0) begin
			pkt.push_back(8'h00);
		end else if (form == 1) begin
			v = 8'($urandom);
			pkt.push_back({LBL_PTR, v[5:0]});
			add_rand(1);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				v = 8'($urandom_range(1, 4));
				pkt.push_back(v);
				add_rand(int'(v));
			end
			if (form == 2) begin
				pkt.push_back(8'h00);
			end else begin
				v = 8'($urandom);
				pkt.push_back({LBL_PTR, v[5:0]});
				add_rand(1);
			end
		end
	endtask

	task automatic add_answer(input logic [15:0] rtype, input logic [15:0] rdlen);
		add_name();
		pkt = {pkt, rtype[15:8], rtype[7:0]};
		add_rand(6);
		pkt = {pkt, rdlen[15:8], rdlen[7:0]};
		add_rand(int'(rdlen));
	endtask

	// ---- driving ----

	task automatic send_byte(input logic [7:0] b, input logic eor);
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			reply.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		reply.valid <= 1'b1;
		reply.reply_byte <= b;
		reply.end_of_reply <= eor;
		do @(posedge clk); while (reply.ready !== 1'b1);
		strip_step(b, eor);
		bytes_sent++;
	endtask

	task automatic send_reply();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// hold off until the block has nothing left to hand out
	task automatic settle();
		@(negedge clk);
		reply.valid <= 1'b0;
		while (buffer_ops.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_drop_type(input logic [15:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		strip_type = v;
	endtask

	// ---- tests ----

	task automatic test_header_errors();
		pkt.delete(); add_rand(1); send_reply();
		pkt.delete(); add_header(16'd1, 16'd0); pkt = pkt[0:10]; send_reply();
		pkt.delete(); add_header(16'd0, 16'd0); send_reply();
		pkt.delete(); add_header(16'd2, 16'd1); add_rand(3); send_reply();
		pkt.delete(); add_header(16'hff00, 16'd0); send_reply();
		// short reply is reported even when the question count is bad
		pkt.delete(); add_header(16'd0, 16'd0); pkt = pkt[0:7]; send_reply();
	endtask

	task automatic test_question_errors();
		pkt.delete(); add_header(16'd1, 16'd0); pkt = {pkt, 8'h40}; add_rand(2); send_reply();
		pkt.delete(); add_header(16'd1, 16'd0); pkt = {pkt, 8'h02}; add_rand(2);
		pkt = {pkt, 8'h80}; add_rand(2); send_reply();
		pkt.delete(); add_header(16'd1, 16'd0); pkt = {pkt, 8'h05}; add_rand(2); send_reply();
		pkt.delete(); add_header(16'd1, 16'd0); pkt = {pkt, 8'hc0}; send_reply();
		pkt.delete(); add_header(16'd1, 16'd0); pkt = {pkt, 8'h00}; add_rand(3); send_reply();
		// longest label, good reply with no answers
		pkt.delete(); add_header(16'd1, 16'd0); pkt = {pkt, 8'h3f}; add_rand(63);
		pkt = {pkt, 8'h00}; add_rand(4); send_reply();
	endtask

	task automatic test_answer_filter();
		pkt.delete(); add_header(16'd1, 16'd3); add_name(); add_rand(4);
		add_answer(16'd1, 16'd4);
		add_answer(strip_type, 16'd3);
		add_answer(16'd28, 16'd0);
		add_rand(5);
		send_reply();
		// every answer removed, one of them with empty data
		pkt.delete(); add_header(16'd1, 16'd2); add_name(); add_rand(4);
		add_answer(strip_type, 16'd0);
		add_answer(strip_type, 16'd2);
		send_reply();
	endtask

	task automatic test_answer_errors();
		pkt.delete(); add_header(16'd1, 16'd1); pkt = {pkt, 8'h00}; add_rand(4);
		pkt = {pkt, 8'h40}; add_rand(3); send_reply();
		pkt.delete(); add_header(16'd1, 16'd1); pkt = {pkt, 8'h00}; add_rand(4);
		add_answer(16'd1, 16'd6); pkt = pkt[0:$-2]; send_reply();
		pkt.delete(); add_header(16'd1, 16'd3); pkt = {pkt, 8'h00}; add_rand(4);
		add_answer(16'd1, 16'd2); send_reply();
		// truncated while the record is being removed
		pkt.delete(); add_header(16'd1, 16'd1); pkt = {pkt, 8'h00}; add_rand(4);
		add_answer(strip_type, 16'd8); pkt = pkt[0:$-3]; send_reply();
	endtask

	// mostly well-formed replies, some cut short, corrupted or pure noise
	task automatic test_random_replies();
		logic [15:0] drops[5];
		int start, mode, cut;
		drops = '{DROP_TYPE_RST, 16'h0000, 16'hffff, 16'd1, 16'($urandom)};
		for (int p = 0; p < 5; p++) begin
			set_drop_type(drops[p]);
			calm = (p == 4);
			start = bytes_sent;
			while (bytes_sent - start < 20) begin
				pkt.delete();
				mode = $urandom_range(0, 9);
				if (mode == 8) begin
					add_rand($urandom_range(1, 20));
				end else begin
					add_header(16'd1, 16'($urandom_range(0, 3)));
					add_name();
					add_rand(4);
					for (int a = 0; a < int'(pkt[7]); a++)
						add_answer($urandom_range(0, 1) ? strip_type : 16'($urandom),
							16'($urandom_range(0, 6)));
					add_rand($urandom_range(0, 5));
					if (mode == 6 || mode == 9) begin
						cut = $urandom_range(0, pkt.size() - 1);
						pkt = pkt[0:cut];
					end
					if (mode == 7)
						pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
				end
				send_reply();
				if ($urandom_range(0, 5) == 0)
					settle();
			end
		end
	endtask

	// ---- result checking ----

	always @(posedge clk) begin
		res_t seen, want;
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			seen.kind = result.kind;
			seen.write_addr = result.write_addr;
			seen.write_data = result.write_data;
			seen.status = result.status;
			seen.out_length = result.out_length;
			seen.final_item = result.final_item;
			if (buffer_ops.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected: kind %0d addr %0d data %02h st %0d len %0d last %0d",
						seen.kind, seen.write_addr, seen.write_data, seen.status,
						seen.out_length, seen.final_item);
			end else begin
				want = buffer_ops.pop_front();
				if (seen !== want) begin
					bad_count++;
					if (bad_count <= 10) begin
						$display("expected kind %0d addr %0d data %02h st %0d len %0d last %0d",
							want.kind, want.write_addr, want.write_data, want.status,
							want.out_length, want.final_item);
						$display("got      kind %0d addr %0d data %02h st %0d len %0d last %0d",
							seen.kind, seen.write_addr, seen.write_data, seen.status,
							seen.out_length, seen.final_item);
					end
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		reply.valid = 1'b0;
		reply.reply_byte = 8'd0;
		reply.end_of_reply = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		calm = 1'b0;
		bad_count = 0;
		bytes_sent = 0;
		strip_type = DROP_TYPE_RST;
		clear_model();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_header_errors();
		test_question_errors();
		test_answer_filter();
		test_answer_errors();
		test_random_replies();

		@(negedge clk);
		reply.valid <= 1'b0;
		waited = 0;
		while (buffer_ops.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_count == 0 && buffer_ops.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
